// ----- sv/spq_pkg.sv -----
// sorted priority queue package: state, status codes and the command and
// status groups between controller and datapath
// no dependencies
package spq_pkg;

    // request kinds on s_tuser
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_POP,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;      // latch request word, status and clear popped
        status_t status;      // status code latched on accept
        logic    scan_start;  // read tail entry, set up shift pointers
        logic    place_tail;  // new entry goes to the tail slot
        logic    shift;       // move read entry up one slot, step back
        logic    place;       // write new entry at fill slot, count up
        logic    pop_take;    // take head payload, advance head, count down
        logic    out_load;    // load the output register
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic j_zero;    // read entry is the head
        logic pri_ge;    // read priority >= new priority
        logic pri_gt;    // read priority > new priority
        logic out_free;  // output register can take a word
    } spq_sts_t;

endpackage

// ----- sv/spq_ctrl.sv -----
// sorted priority queue controller: request sequencing state machine
// depends on spq_pkg
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     req_type,
    input  spq_sts_t sts,
    output logic     s_tready,
    output spq_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.status = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == REQ_PUSH)
                    begin
                        if (sts.full)
                        begin
                            cmd.status = STAT_FULL;
                            state_next = ST_FINISH;
                        end
                        else if (sts.empty)
                        begin
                            cmd.place_tail = 1'b1;
                            state_next     = ST_PLACE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = STAT_EMPTY;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            // head read is the default memory address
                            state_next = ST_POP;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (!sts.j_zero)
                begin
                    if (sts.pri_ge)
                    begin
                        cmd.shift = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    // head moves back only when strictly greater
                    cmd.shift  = sts.pri_gt;
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_POP:
            begin
                cmd.pop_take = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/spq_dp.sv -----
// sorted priority queue datapath: circular entry memory, pointers, count,
// request latch and output register
// depends on spq_pkg
module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int PAYLOAD_BITS  = 32,
    parameter int PRIORITY_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [PRIORITY_BITS-1:0]          in_priority,
    input  logic [PAYLOAD_BITS-1:0]           in_payload,
    input  spq_cmd_t                          cmd,
    input  logic                              m_tready,
    output spq_sts_t                          sts,
    output logic                              out_valid,
    output status_t                           out_status,
    output logic [PAYLOAD_BITS-1:0]           out_popped,
    output logic [$clog2(CAPACITY+1)-1:0]     out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;

    logic [EW-1:0]            entry_mem [CAPACITY];
    logic [EW-1:0]            rd_data_reg;
    logic [AW-1:0]            head_reg;
    logic [AW-1:0]            head_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [AW-1:0]            rd_ptr_reg;
    logic [AW-1:0]            wr_ptr_reg;
    logic [AW-1:0]            j_reg;
    logic [PRIORITY_BITS-1:0] req_pri_reg;
    logic [PAYLOAD_BITS-1:0]  req_pay_reg;
    status_t                  status_reg;
    logic [PAYLOAD_BITS-1:0]  popped_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    logic [PAYLOAD_BITS-1:0]  out_popped_reg;
    logic [CW-1:0]            out_count_reg;

    logic [AW:0]              tail_sum;
    logic [AW-1:0]            tail;
    logic [AW-1:0]            rd_addr;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic [PAYLOAD_BITS-1:0]  rd_pay;

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    // tail slot = head + count, wrapped once
    assign tail_sum = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail     = (tail_sum >= (AW+1)'(CAPACITY)) ?
                      AW'(tail_sum - (AW+1)'(CAPACITY)) : AW'(tail_sum);

    always_comb
    begin
        if (cmd.scan_start)
        begin
            rd_addr = ptr_dec(tail);
        end
        else if (cmd.shift)
        begin
            rd_addr = ptr_dec(rd_ptr_reg);
        end
        else
        begin
            rd_addr = head_reg;
        end
    end

    assign rd_pri = rd_data_reg[EW-1 -: PRIORITY_BITS];
    assign rd_pay = rd_data_reg[PAYLOAD_BITS-1:0];

    assign sts.full     = (count_reg == CW'(CAPACITY));
    assign sts.empty    = (count_reg == '0);
    assign sts.j_zero   = (j_reg == '0);
    assign sts.pri_ge   = (rd_pri >= req_pri_reg);
    assign sts.pri_gt   = (rd_pri > req_pri_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            entry_mem[wr_ptr_reg] <= rd_data_reg;
        end
        else if (cmd.place)
        begin
            entry_mem[wr_ptr_reg] <= {req_pri_reg, req_pay_reg};
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (cmd.place)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop_take)
        begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_pri_reg <= in_priority;
            req_pay_reg <= in_payload;
            status_reg  <= cmd.status;
            popped_reg  <= '0;
        end
        if (cmd.scan_start)
        begin
            rd_ptr_reg <= ptr_dec(tail);
            wr_ptr_reg <= tail;
            j_reg      <= AW'(count_reg - CW'(1));
        end
        else if (cmd.place_tail)
        begin
            wr_ptr_reg <= tail;
        end
        else if (cmd.shift)
        begin
            wr_ptr_reg <= rd_ptr_reg;
            rd_ptr_reg <= ptr_dec(rd_ptr_reg);
            j_reg      <= j_reg - AW'(1);
        end
        if (cmd.pop_take)
        begin
            popped_reg <= rd_pay;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_popped_reg <= popped_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_popped = out_popped_reg;
    assign out_count  = out_count_reg;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// sorted priority queue top level: stream ports, controller and datapath
// depends on spq_pkg, spq_ctrl, spq_dp
//
// min-priority queue held in ascending priority order in a circular memory
// of CAPACITY entries. each input word is one request (push or pop) and
// gives exactly one output word with status, popped payload and the entry
// count after the request. the output word appears in the cycle where
// s_tready is high again. a pop removes the head by advancing the head
// pointer. a push walks the list from the tail toward the head, moving each
// entry whose priority is not lower than the new one (the head only when
// strictly higher) up by one slot, one entry per cycle through the memory's
// single read and write port. a push to a full queue or a pop on an empty
// queue leaves the queue as it was. the output word sits in a register, so a
// new request is taken while the previous word still waits on m_tready; the
// next request's finish step then waits for that word to leave. no clearing
// pass is needed after reset: only slots holding live entries are ever used.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int PAYLOAD_BITS  = 32,
    parameter int PRIORITY_BITS = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata: priority_req, payload, zero fill
    input  logic [((PRIORITY_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: req_type
    input  logic                                   s_tuser,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // m_tdata: popped_payload, entry_count, zero fill
    output logic [((PAYLOAD_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata,
    // m_tuser: status
    output logic [1:0]                             m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int OUT_W = ((PAYLOAD_BITS + CW + 7) / 8) * 8;

    spq_cmd_t                cmd;
    spq_sts_t                sts;
    status_t                 out_status;
    logic [PAYLOAD_BITS-1:0] out_popped;
    logic [CW-1:0]           out_count;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    spq_dp #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_BITS  (PAYLOAD_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_priority (s_tdata[PRIORITY_BITS-1:0]),
        .in_payload  (s_tdata[PRIORITY_BITS +: PAYLOAD_BITS]),
        .cmd         (cmd),
        .m_tready    (m_tready),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_popped  (out_popped),
        .out_count   (out_count)
    );

    // pack the output word, count above payload, zero fill on top
    assign m_tdata = OUT_W'({out_count, out_popped});
    assign m_tuser = out_status;

endmodule

// ----- sv/spq_checker.sv -----
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int PAYLOAD_BITS  = 32,
    parameter int PRIORITY_BITS = 16
)
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic [((PRIORITY_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
    input logic                                   s_tuser,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [((PAYLOAD_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata,
    input logic [1:0]                             m_tuser,
    input logic                                   m_tvalid,
    input logic                                   m_tready
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [PAYLOAD_BITS-1:0] popped;
    logic [CW-1:0]           count;

    assign popped = m_tdata[PAYLOAD_BITS-1:0];
    assign count  = m_tdata[PAYLOAD_BITS +: CW];

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // an empty pop reports an empty queue and no payload
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_EMPTY |-> count == '0 && popped == '0)
        else $error("empty status with nonzero count or payload");

    // a dropped push reports a full queue and no payload
    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_FULL |-> count == CW'(CAPACITY) && popped == '0)
        else $error("full status with wrong count or payload");

    // count never passes capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a request is never taken in the cycle after the prior request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken right after the first");

endmodule

bind sorted_priority_queue spq_checker #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (.*);
